>>> rtl/windowed_sinc_lowpass_coef_macros.svh
// assertion helpers for the coefficient generator
`ifndef WINDOWED_SINC_LOWPASS_COEF_MACROS_SVH
`define WINDOWED_SINC_LOWPASS_COEF_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define WSL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent delayed by the dly argument, sampled on clk, off while in reset
`define WSL_ASSERT_DELAY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

>>> rtl/wsl_pkg.sv
`default_nettype none

package wsl_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_LAT   = CORDIC_STEPS / 2 + 2;

    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] INV_PI_Q32      = 32'd1367130551;
    localparam logic [31:0] W54_Q30         = 32'd579820585;
    localparam logic [31:0] W64_Q30         = 32'd687194767;

    typedef enum logic [1:0] {
        CFG_TAP_COUNT    = 2'd0,
        CFG_CUTOFF_RATIO = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic valid;
        logic beyond;
    } wsl_side_t;

    typedef struct packed {
        logic [CORDIC_W-1:0] x;
        logic [CORDIC_W-1:0] y;
        logic [CORDIC_W-1:0] z;
    } cordic_vec_t;

    // arctangent of 2^-k in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] a;
        case (k)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // one micro-rotation, k is constant at every call site
    function automatic cordic_vec_t cordic_rot(input cordic_vec_t v, input int k);
        cordic_vec_t r;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        logic signed [CORDIC_W-1:0] at;
        dx = $signed(v.y) >>> k;
        dy = $signed(v.x) >>> k;
        at = $signed({2'b00, atan_turn(k)});
        if (!v.z[CORDIC_W-1])
        begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - at;
        end
        else
        begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + at;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/wsl_delay.sv
`default_nettype none

module wsl_delay
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [WIDTH-1:0] d,
    output logic      [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

>>> rtl/wsl_div.sv
`default_nettype none

module wsl_div
#(
    parameter int NUM_W = 64,
    parameter int DEN_W = 8,
    parameter int BPS   = 8
)
(
    input  wire logic             clk,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quot
);

    localparam int NS = NUM_W / BPS;

    logic [DEN_W-1:0] rem_s [0:NS];
    logic [NUM_W-1:0] nq_s  [0:NS];
    logic [DEN_W-1:0] den_s [0:NS];

    // restoring steps, quotient bits shift in behind the dividend
    function automatic logic [DEN_W+NUM_W-1:0] div_steps(
        input logic [DEN_W-1:0] rem_in,
        input logic [NUM_W-1:0] nq_in,
        input logic [DEN_W-1:0] dv
    );
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] r;
        logic [NUM_W-1:0] nq;
        r  = rem_in;
        nq = nq_in;
        for (int i = 0; i < BPS; i++)
        begin
            t  = {r, nq[NUM_W-1]};
            nq = {nq[NUM_W-2:0], 1'b0};
            if (t >= {1'b0, dv})
            begin
                t     = t - {1'b0, dv};
                nq[0] = 1'b1;
            end
            r = t[DEN_W-1:0];
        end
        return {r, nq};
    endfunction

    assign rem_s[0] = '0;
    assign nq_s[0]  = num;
    assign den_s[0] = den;

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            {rem_s[g+1], nq_s[g+1]} <= div_steps(rem_s[g], nq_s[g], den_s[g]);
            den_s[g+1]              <= den_s[g];
        end
    end

    assign quot = nq_s[NS];

endmodule

`default_nettype wire

>>> rtl/wsl_cordic.sv
`default_nettype none

module wsl_cordic
    import wsl_pkg::*;
#(
    parameter bit OUT_SIN = 1'b1
)
(
    input  wire logic               clk,
    input  wire logic        [31:0] phase,
    output logic signed      [31:0] result
);

    localparam int NSTG = CORDIC_STEPS / 2;

    cordic_vec_t       v_reg    [0:NSTG];
    logic        [1:0] quad_reg [0:NSTG];
    logic signed [31:0] result_reg;
    logic signed [31:0] result_next;
    logic signed [31:0] xs;
    logic signed [31:0] ys;

    always_ff @(posedge clk)
    begin
        v_reg[0].x  <= CORDIC_W'(CORDIC_GAIN_Q30);
        v_reg[0].y  <= '0;
        v_reg[0].z  <= {4'b0000, phase[29:0]};
        quad_reg[0] <= phase[31:30];
    end

    // two rotations per stage
    for (genvar st = 0; st < NSTG; st++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            v_reg[st+1]    <= cordic_rot(cordic_rot(v_reg[st], 2*st), 2*st + 1);
            quad_reg[st+1] <= quad_reg[st];
        end
    end

    assign xs = $signed(v_reg[NSTG].x[31:0]);
    assign ys = $signed(v_reg[NSTG].y[31:0]);

    // fold the quadrant back in
    always_comb
    begin
        case (quad_reg[NSTG])
            2'd0:    result_next = OUT_SIN ? ys  : xs;
            2'd1:    result_next = OUT_SIN ? xs  : -ys;
            2'd2:    result_next = OUT_SIN ? -ys : -xs;
            default: result_next = OUT_SIN ? -xs : ys;
        endcase
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/windowed_sinc_lowpass_coef.sv
// channel   | signals                                         | direction
// ----------+-------------------------------------------------+----------
// command   | start, busy, tap_index                          | in, busy out
// result    | result_valid, coefficient, index_beyond         | out
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data       | in, cfg_ready out
//
// one index is taken every cycle; busy stays low, the pipeline never stops
// each result follows its start beat through the sine path, in order:
// cordic, scaling multiply, divide by n (8 stages of 8 bits), rounding
// reset clears the valid bits and loads tap_count 11 and cutoff_ratio 1486
// results are strobed for one cycle; the receiver cannot stall them
`default_nettype none

`include "windowed_sinc_lowpass_coef_macros.svh"

module windowed_sinc_lowpass_coef
    import wsl_pkg::*;
#(
    parameter int MAX_TAPS       = 255,
    parameter int COEF_FRAC_BITS = 16
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic        [7:0]                tap_index,
    output logic                                  result_valid,
    output logic signed      [COEF_FRAC_BITS+1:0] coefficient,
    output logic                                  index_beyond,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic        [1:0]                cfg_index,
    input  wire logic        [15:0]               cfg_data
);

    localparam int SDIV_NUM_W = 64;
    localparam int CDIV_NUM_W = 40;
    localparam int DIV_BPS    = 8;
    localparam int SDIV_LAT   = SDIV_NUM_W / DIV_BPS;
    localparam int CDIV_LAT   = CDIV_NUM_W / DIV_BPS;
    localparam int SIN_LAT    = CORDIC_LAT + SDIV_LAT + 4;
    localparam int COS_LAT    = CDIV_LAT + CORDIC_LAT + 2;
    localparam int TOTAL_LAT  = SIN_LAT + 5;
    localparam int SHIFT      = 60 - COEF_FRAC_BITS;
    localparam int OUT_W      = COEF_FRAC_BITS + 2;

    localparam logic [7:0] LEN_CLAMP = 8'((MAX_TAPS - 1) | 1);
    localparam logic signed [65:0] ROUND_ADD = 66'sd1 <<< (SHIFT - 1);
    localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (COEF_FRAC_BITS + 1)) - 66'sd1;
    localparam logic signed [65:0] SAT_LO = -(66'sd1 <<< (COEF_FRAC_BITS + 1));
    localparam logic signed [32:0] INV_PI_S = $signed({1'b0, INV_PI_Q32});
    localparam logic signed [32:0] W64_S    = $signed({1'b0, W64_Q30});
    localparam logic signed [63:0] SINC_RND = 64'sd2147483648;
    localparam logic signed [62:0] WIN_RND  = 63'sd536870912;

    // configuration
    logic [7:0]  tap_count_reg;
    logic [15:0] cutoff_ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg    <= 8'd11;
            cutoff_ratio_reg <= 16'd1486;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TAP_COUNT:    tap_count_reg    <= cfg_data[7:0];
                CFG_CUTOFF_RATIO: cutoff_ratio_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    logic       accept;
    logic [7:0] len_raw;
    logic [7:0] len_eff;

    assign accept  = start && !busy;
    assign len_raw = tap_count_reg | 8'd1;
    assign len_eff = (int'(len_raw) > MAX_TAPS) ? LEN_CLAMP : len_raw;

    // stage 1: capture
    logic        s1_valid_reg;
    logic [7:0]  s1_idx_reg;
    logic [7:0]  s1_len_reg;
    logic [15:0] s1_ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= tap_index;
        s1_len_reg   <= len_eff;
        s1_ratio_reg <= cutoff_ratio_reg;
    end

    // stage 2: offsets and phases
    logic signed [9:0]  n2;
    logic signed [9:0]  an2;
    logic signed [26:0] sprod;
    logic        [31:0] sphase;
    logic        [39:0] cnum;
    wsl_side_t          s1_side;

    assign n2     = $signed({1'b0, s1_idx_reg, 1'b0}) - $signed({2'b00, s1_len_reg});
    assign an2    = n2[9] ? -n2 : n2;
    assign sprod  = 27'(n2) * 27'($signed({1'b0, s1_ratio_reg}));
    assign sphase = {sprod[16:0], 15'b0};
    // round half up of |n2| * 2^30 / len
    assign cnum   = 40'({an2[7:0], 30'b0}) + 40'(s1_len_reg[7:1]);

    assign s1_side.valid  = s1_valid_reg;
    assign s1_side.beyond = s1_idx_reg >= s1_len_reg;

    wsl_side_t          s2_side_reg;
    logic        [31:0] s2_sphase_reg;
    logic        [39:0] s2_cnum_reg;
    logic        [7:0]  s2_len_reg;
    logic signed [9:0]  s2_n2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_side_reg <= '0;
        end
        else
        begin
            s2_side_reg <= s1_side;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_sphase_reg <= sphase;
        s2_cnum_reg   <= cnum;
        s2_len_reg    <= s1_len_reg;
        s2_n2_reg     <= n2;
    end

    // sine path: sin, times 2/pi, divided by n2
    logic signed [31:0] sin_val;
    logic        [9:0]  n2_d;

    wsl_cordic #(.OUT_SIN(1'b1)) u_sin_cordic
    (
        .clk    (clk),
        .phase  (s2_sphase_reg),
        .result (sin_val)
    );

    wsl_delay #(.WIDTH(10), .DEPTH(CORDIC_LAT + 1)) u_n2_dly
    (
        .clk   (clk),
        .rst_n (rst_n),
        .d     (s2_n2_reg),
        .q     (n2_d)
    );

    logic signed [64:0] pmul;
    logic signed [63:0] prod_p_reg;
    logic        [63:0] mag_reg;
    logic        [7:0]  den_reg;
    logic               neg_reg;
    logic        [9:0]  an2_d;

    assign pmul  = 65'(sin_val) * 65'(INV_PI_S);
    assign an2_d = n2_d[9] ? (~n2_d + 10'd1) : n2_d;

    always_ff @(posedge clk)
    begin
        prod_p_reg <= {pmul[62:0], 1'b0};
        mag_reg    <= prod_p_reg[63] ? 64'(-prod_p_reg) : 64'(prod_p_reg);
        neg_reg    <= prod_p_reg[63] ^ n2_d[9];
        den_reg    <= an2_d[7:0];
    end

    logic [63:0] squot;
    logic        neg_d;

    wsl_div #(.NUM_W(SDIV_NUM_W), .DEN_W(8), .BPS(DIV_BPS)) u_sinc_div
    (
        .clk  (clk),
        .num  (mag_reg),
        .den  (den_reg),
        .quot (squot)
    );

    wsl_delay #(.WIDTH(1), .DEPTH(SDIV_LAT)) u_neg_dly
    (
        .clk   (clk),
        .rst_n (rst_n),
        .d     (neg_reg),
        .q     (neg_d)
    );

    logic signed [63:0] qs_reg;
    logic signed [63:0] qs_rnd;
    logic signed [33:0] sinc_reg;

    assign qs_rnd = (qs_reg + SINC_RND) >>> 32;

    always_ff @(posedge clk)
    begin
        qs_reg   <= neg_d ? -$signed(squot) : $signed(squot);
        sinc_reg <= qs_rnd[33:0];
    end

    // window path: cos phase by division, then cos, then scale
    logic [39:0] cquot;

    wsl_div #(.NUM_W(CDIV_NUM_W), .DEN_W(8), .BPS(DIV_BPS)) u_cphase_div
    (
        .clk  (clk),
        .num  (s2_cnum_reg),
        .den  (s2_len_reg),
        .quot (cquot)
    );

    logic signed [31:0] cos_val;

    wsl_cordic #(.OUT_SIN(1'b0)) u_cos_cordic
    (
        .clk    (clk),
        .phase  (cquot[31:0]),
        .result (cos_val)
    );

    logic signed [64:0] wmul;
    logic signed [62:0] wprod_reg;
    logic signed [62:0] wrnd;
    logic signed [31:0] win_reg;
    logic        [31:0] win_d;

    assign wmul = 65'(cos_val) * 65'(W64_S);
    assign wrnd = (wprod_reg + WIN_RND) >>> 30;

    always_ff @(posedge clk)
    begin
        wprod_reg <= wmul[62:0];
        win_reg   <= $signed(W54_Q30) + wrnd[31:0];
    end

    wsl_delay #(.WIDTH(32), .DEPTH(SIN_LAT - COS_LAT)) u_win_dly
    (
        .clk   (clk),
        .rst_n (rst_n),
        .d     (win_reg),
        .q     (win_d)
    );

    wsl_side_t side_d;

    wsl_delay #(.WIDTH($bits(wsl_side_t)), .DEPTH(SIN_LAT)) u_side_dly
    (
        .clk   (clk),
        .rst_n (rst_n),
        .d     (s2_side_reg),
        .q     (side_d)
    );

    // product, rounding, saturation
    wsl_side_t          f1_side_reg;
    wsl_side_t          f2_side_reg;
    logic signed [65:0] fprod_reg;
    logic signed [65:0] frnd_reg;
    logic               out_valid_reg;
    logic               out_beyond_reg;
    logic signed [OUT_W-1:0] coef_reg;
    logic signed [OUT_W-1:0] coef_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_side_reg   <= '0;
            f2_side_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            f1_side_reg   <= side_d;
            f2_side_reg   <= f1_side_reg;
            out_valid_reg <= f2_side_reg.valid;
        end
    end

    always_comb
    begin
        if (f2_side_reg.beyond)
        begin
            coef_next = '0;
        end
        else if (frnd_reg > SAT_HI)
        begin
            coef_next = SAT_HI[OUT_W-1:0];
        end
        else if (frnd_reg < SAT_LO)
        begin
            coef_next = SAT_LO[OUT_W-1:0];
        end
        else
        begin
            coef_next = frnd_reg[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        fprod_reg      <= 66'(sinc_reg) * 66'($signed(win_d));
        frnd_reg       <= (fprod_reg + ROUND_ADD) >>> SHIFT;
        coef_reg       <= coef_next;
        out_beyond_reg <= f2_side_reg.beyond;
    end

    assign result_valid = out_valid_reg;
    assign coefficient  = coef_reg;
    assign index_beyond = out_beyond_reg;

    `WSL_ASSERT_DELAY(a_result_follows, start && !busy, TOTAL_LAT, result_valid, "result missing")
    `WSL_ASSERT_IMP(a_no_extra, result_valid, $past(start && !busy, TOTAL_LAT), "result without start")
    `WSL_ASSERT_IMP(a_beyond_zero, result_valid && index_beyond, coefficient == '0, "beyond not zero")

endmodule

`default_nettype wire

>>> tb/windowed_sinc_lowpass_coef_tb.sv
`timescale 1ns / 1ps

module windowed_sinc_lowpass_coef_tb;
    import wsl_pkg::*;

    localparam int FRAC     = 16;
    localparam int LIMIT    = 5000;
    localparam int LATENCY  = 31;

    typedef struct {
        logic signed [FRAC+1:0] coef;
        logic                   beyond;
    } coef_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [7:0]             tap_index;
    logic                   result_valid;
    logic signed [FRAC+1:0] coefficient;
    logic                   index_beyond;
    logic                   cfg_valid;
    logic                   cfg_ready;
    cfg_idx_t               cfg_index;
    logic [15:0]            cfg_data;

    coef_t    coef_q[$];
    int       errors;
    int       stall_cnt;
    int       idle_pct;
    bit [7:0] taps_set;
    bit [15:0] ratio_set;

    longint atan_tab[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    windowed_sinc_lowpass_coef DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .tap_index    (tap_index),
        .result_valid (result_valid),
        .coefficient  (coefficient),
        .index_beyond (index_beyond),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // rotation over the first quadrant, then mapped by the top two phase bits
    task automatic rotate(input logic [31:0] phase, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        z = longint'(phase[29:0]);
        for (int k = 0; k < 24; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - atan_tab[k];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + atan_tab[k];
            end
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic predict_coef(input logic [7:0] idx, output coef_t r);
        longint len;
        longint n2;
        longint an2;
        longint s;
        longint c;
        longint unused;
        longint sinc;
        longint win;
        longint coef;
        logic [63:0] prod;
        logic [31:0] sph;
        logic [31:0] cph;
        len = longint'(taps_set | 8'd1);
        if (len > 255)
            len = 255;
        if (longint'(idx) >= len)
        begin
            r.coef = '0;
            r.beyond = 1'b1;
            return;
        end
        n2 = 2 * longint'(idx) - len;
        an2 = (n2 < 0) ? -n2 : n2;
        prod = 64'(n2) * 64'(ratio_set);
        sph = {prod[16:0], 15'b0};
        rotate(sph, unused, s);
        sinc = (s * 2 * longint'(INV_PI_Q32)) / n2;
        sinc = round_shift(sinc, 32);
        cph = 32'(((64'(an2) << 30) + 64'(len / 2)) / 64'(len));
        rotate(cph, c, unused);
        win = longint'(W54_Q30) + round_shift(c * longint'(W64_Q30), 30);
        coef = round_shift(sinc * win, 60 - FRAC);
        if (coef > 131071)
            coef = 131071;
        if (coef < -131072)
            coef = -131072;
        r.coef = coef[FRAC+1:0];
        r.beyond = 1'b0;
    endtask

    always @(posedge clk)
    begin
        coef_t e;
        if (rst_n && result_valid)
        begin
            if (coef_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: coef %0d beyond %0b",
                             coefficient, index_beyond);
            end
            else
            begin
                e = coef_q.pop_front();
                if (e.coef !== coefficient || e.beyond !== index_beyond)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: coef exp %0d got %0d, beyond exp %0b got %0b",
                                 e.coef, coefficient, e.beyond, index_beyond);
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] idx);
        coef_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        tap_index <= idx;
        do
            @(posedge clk);
        while (busy);
        predict_coef(idx, r);
        coef_q.push_back(r);
        @(negedge clk);
    endtask

    // waits for the pipeline to drain before touching a register
    task automatic write_reg(input cfg_idx_t which, input logic [15:0] data);
        start <= 1'b0;
        wait (coef_q.size() == 0);
        repeat (LATENCY + 4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (which == CFG_TAP_COUNT)
            taps_set = data[7:0];
        else
            ratio_set = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_item(8'd0);
        send_item(8'd5);
        send_item(8'd10);
        send_item(8'd11);
        send_item(8'd255);
    endtask

    task automatic test_tap_extremes();
        write_reg(CFG_TAP_COUNT, 16'd0);
        send_item(8'd0);
        send_item(8'd1);
        write_reg(CFG_TAP_COUNT, 16'd255);
        send_item(8'd0);
        send_item(8'd127);
        send_item(8'd254);
        send_item(8'd255);
        write_reg(CFG_TAP_COUNT, 16'd254);
        send_item(8'd253);
        send_item(8'd254);
    endtask

    task automatic test_ratio_extremes();
        write_reg(CFG_CUTOFF_RATIO, 16'd65535);
        send_item(8'd0);
        send_item(8'd254);
        write_reg(CFG_CUTOFF_RATIO, 16'd0);
        send_item(8'd3);
        write_reg(CFG_TAP_COUNT, 16'd3);
        write_reg(CFG_CUTOFF_RATIO, 16'd32768);
        send_item(8'd0);
        send_item(8'd1);
        send_item(8'd2);
    endtask

    task automatic test_random(input int pct, input int count);
        int len;
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                write_reg(CFG_TAP_COUNT, 16'($urandom_range(255)));
                if ($urandom_range(9) == 0)
                    write_reg(CFG_CUTOFF_RATIO, 16'($urandom_range(65535)));
                else
                    write_reg(CFG_CUTOFF_RATIO, 16'($urandom_range(32768)));
                idle_pct = pct;
            end
            len = int'(taps_set | 8'd1);
            if ($urandom_range(99) < 85)
                send_item(8'($urandom_range(len - 1)));
            else
                send_item(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        tap_index = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TAP_COUNT;
        cfg_data  = '0;
        errors    = 0;
        idle_pct  = 0;
        taps_set  = 8'd11;
        ratio_set = 16'd1486;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_values();
        test_tap_extremes();
        test_ratio_extremes();
        test_random(0, 480);
        test_random(76, 480);
        test_random(0, 480);
        test_random(16, 480);

        start <= 1'b0;
        wait (coef_q.size() == 0);
        repeat (LATENCY + 10) @(negedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
